[sv/ctp_pkg.sv]
// Shared widths and the queue entry type for the closest point on triangle block.
package ctp_pkg;

  localparam int COORD_W  = 32;
  localparam int DIFF_W   = 33;
  localparam int DOT_W    = 68;
  localparam int PROD_W   = 136;
  localparam int WIDE_W   = 137;
  localparam int SIDE_W   = 70;
  localparam int NUM_W    = 171;
  localparam int DEN_W    = 137;
  localparam int BASE_W   = 34;
  localparam int QBITS    = 41;
  localparam int REM_W    = 180;
  localparam int CHUNK_W  = 34;
  localparam int REGION_W = 3;

  typedef struct packed {
    logic [2:0][NUM_W-1:0]  num;
    logic [DEN_W-1:0]       den;
    logic [2:0][BASE_W-1:0] base;
    logic [REGION_W-1:0]    region;
  } item_t;

endpackage

[sv/ctp_if.sv]
// Query and result channel interfaces.
interface ctp_query_if;
  logic valid;
  logic ready;
  logic signed [31:0] vertex_a_x;
  logic signed [31:0] vertex_a_y;
  logic signed [31:0] vertex_a_z;
  logic signed [31:0] vertex_b_x;
  logic signed [31:0] vertex_b_y;
  logic signed [31:0] vertex_b_z;
  logic signed [31:0] vertex_c_x;
  logic signed [31:0] vertex_c_y;
  logic signed [31:0] vertex_c_z;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic signed [31:0] query_z;

  modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                  vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y, query_z,
                  input ready);
  modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, query_x, query_y, query_z,
                output ready);
endinterface

interface ctp_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] closest_x;
  logic signed [31:0] closest_y;
  logic signed [31:0] closest_z;
  logic [2:0] region;

  modport source (output valid, closest_x, closest_y, closest_z, region, input ready);
  modport sink (input valid, closest_x, closest_y, closest_z, region, output ready);
endinterface

[sv/ctp_mul.sv]
// Two-stage signed multiplier built from registered chunk partial products.
module ctp_mul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW = ctp_pkg::CHUNK_W;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int SW = (NA + NB) * CW + 2;

  logic [NA*CW-1:0] ax;
  logic [NB*CW-1:0] bx;
  logic signed [2*CW+1:0] pp [NA][NB];
  logic signed [SW-1:0] acc;

  assign ax = (NA*CW)'(a);
  assign bx = (NB*CW)'(b);

  for (genvar i = 0; i < NA; i++) begin : g_a
    for (genvar j = 0; j < NB; j++) begin : g_b
      logic signed [CW:0] ai;
      logic signed [CW:0] bj;
      assign ai = (i == NA - 1) ? $signed({ax[NA*CW-1], ax[i*CW +: CW]})
                                : $signed({1'b0, ax[i*CW +: CW]});
      assign bj = (j == NB - 1) ? $signed({bx[NB*CW-1], bx[j*CW +: CW]})
                                : $signed({1'b0, bx[j*CW +: CW]});
      always_ff @(posedge clk) begin
        if (en) begin
          pp[i][j] <= ai * bj;
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp[i][j]) <<< (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[AW+BW-1:0];
    end
  end

endmodule

[sv/ctp_front.sv]
// Front pipeline: edge vectors, dot products, region classification and numerators.
module ctp_front (
  input  logic           clk,
  input  logic           rst,
  ctp_query_if.sink      query,
  input  logic           full,
  output logic           push,
  output ctp_pkg::item_t item
);

  localparam int DW = ctp_pkg::DIFF_W;
  localparam int SD = ctp_pkg::SIDE_W;
  localparam int WW = ctp_pkg::WIDE_W;
  localparam int BS = ctp_pkg::BASE_W;
  localparam int RW = ctp_pkg::REGION_W;

  localparam logic [RW-1:0] RGN_INTERIOR = 3'd0;
  localparam logic [RW-1:0] RGN_BC       = 3'd1;
  localparam logic [RW-1:0] RGN_BC_AC    = 3'd2;
  localparam logic [RW-1:0] RGN_AC       = 3'd3;
  localparam logic [RW-1:0] RGN_VERTEX_A = 3'd4;
  localparam logic [RW-1:0] RGN_AB       = 3'd5;
  localparam logic [RW-1:0] RGN_BC_AB    = 3'd6;

  typedef enum logic [1:0] {SEG_AB, SEG_AC, SEG_BC, SEG_NONE} seg_t;

  logic en;
  logic [10:1] vld;

  logic [2:0][31:0] in_a, in_b, in_c, in_q;
  logic [2:0][31:0] pa_p [1:6];
  logic [2:0][31:0] pc_p [1:6];
  logic [2:0][DW-1:0] e0_p [1:6];
  logic [2:0][DW-1:0] e1_p [1:6];
  logic [2:0][DW-1:0] bc_p [1:6];
  logic [2:0][DW-1:0] dv1;

  logic signed [67:0] a2, b2, c2, d2, e2;
  logic signed [135:0] p_ac, p_bb, p_be, p_cd, p_bd, p_ae;

  logic signed [SD-1:0] nd_p [3:6];
  logic signed [SD-1:0] ne_p [3:6];
  logic signed [SD-1:0] bn_p [3:6];
  logic signed [SD-1:0] bd_p [3:6];
  logic signed [SD-1:0] a_p [3:6];
  logic signed [SD-1:0] c_p [3:6];
  logic dneg_p [3:5];
  logic cegt_p [3:5];
  logic adgt_p [3:5];

  logic signed [WW-1:0] det_p [5:6];
  logic signed [WW-1:0] s_p [5:6];
  logic signed [WW-1:0] t_p [5:6];

  logic signed [WW:0] sum5;
  logic lt5;
  logic [RW-1:0] region_c;
  seg_t seg_c;
  logic [RW-1:0] region6;
  seg_t seg6;
  logic [2:0] lo6, hi6;

  logic signed [SD-1:0] e_num, e_den;
  logic e_lo, e_hi;
  logic [2:0][31:0] e_p0;
  logic [2:0][DW-1:0] e_v;
  logic signed [WW-1:0] x_sel, y_sel, den_sel;
  logic [2:0][DW-1:0] u_sel, w_sel;
  logic [2:0][BS-1:0] base_sel;

  logic signed [WW-1:0] x7, y7;
  logic [2:0][DW-1:0] u7, w7;
  logic [WW-1:0] den_p [7:10];
  logic [2:0][BS-1:0] base_p [7:10];
  logic [RW-1:0] rg_p [7:10];
  logic signed [169:0] px [3];
  logic signed [169:0] py [3];
  logic [2:0][ctp_pkg::NUM_W-1:0] n10;

  function automatic logic signed [67:0] dot3(logic [2:0][DW-1:0] u, logic [2:0][DW-1:0] v);
    logic signed [67:0] acc;
    logic signed [65:0] pr;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      pr = $signed(u[i]) * $signed(v[i]);
      acc = acc + 68'(pr);
    end
    return acc;
  endfunction

  assign en = !(vld[10] && full);
  assign query.ready = en;
  assign push = en && vld[10];

  assign in_a = {query.vertex_a_z, query.vertex_a_y, query.vertex_a_x};
  assign in_b = {query.vertex_b_z, query.vertex_b_y, query.vertex_b_x};
  assign in_c = {query.vertex_c_z, query.vertex_c_y, query.vertex_c_x};
  assign in_q = {query.query_z, query.query_y, query.query_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], query.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0_p[1][i] <= 33'($signed(in_b[i])) - 33'($signed(in_a[i]));
        e1_p[1][i] <= 33'($signed(in_c[i])) - 33'($signed(in_a[i]));
        bc_p[1][i] <= 33'($signed(in_b[i])) - 33'($signed(in_c[i]));
        dv1[i]     <= 33'($signed(in_a[i])) - 33'($signed(in_q[i]));
      end
      pa_p[1] <= in_a;
      pc_p[1] <= in_c;
      for (int k = 2; k <= 6; k++) begin
        pa_p[k] <= pa_p[k-1];
        pc_p[k] <= pc_p[k-1];
        e0_p[k] <= e0_p[k-1];
        e1_p[k] <= e1_p[k-1];
        bc_p[k] <= bc_p[k-1];
      end

      a2 <= dot3(e0_p[1], e0_p[1]);
      b2 <= dot3(e0_p[1], e1_p[1]);
      c2 <= dot3(e1_p[1], e1_p[1]);
      d2 <= dot3(e0_p[1], dv1);
      e2 <= dot3(e1_p[1], dv1);

      nd_p[3]   <= -SD'(d2);
      ne_p[3]   <= -SD'(e2);
      bd_p[3]   <= SD'(a2) - SD'(b2) - SD'(b2) + SD'(c2);
      bn_p[3]   <= SD'(c2) + SD'(e2) - SD'(b2) - SD'(d2);
      a_p[3]    <= SD'(a2);
      c_p[3]    <= SD'(c2);
      dneg_p[3] <= d2[67];
      cegt_p[3] <= (SD'(c2) + SD'(e2)) > (SD'(b2) + SD'(d2));
      adgt_p[3] <= (SD'(a2) + SD'(d2)) > (SD'(b2) + SD'(e2));
      for (int k = 4; k <= 6; k++) begin
        nd_p[k] <= nd_p[k-1];
        ne_p[k] <= ne_p[k-1];
        bd_p[k] <= bd_p[k-1];
        bn_p[k] <= bn_p[k-1];
        a_p[k]  <= a_p[k-1];
        c_p[k]  <= c_p[k-1];
      end
      for (int k = 4; k <= 5; k++) begin
        dneg_p[k] <= dneg_p[k-1];
        cegt_p[k] <= cegt_p[k-1];
        adgt_p[k] <= adgt_p[k-1];
      end

      det_p[5] <= WW'(p_ac) - WW'(p_bb);
      s_p[5]   <= WW'(p_be) - WW'(p_cd);
      t_p[5]   <= WW'(p_bd) - WW'(p_ae);
      det_p[6] <= det_p[5];
      s_p[6]   <= s_p[5];
      t_p[6]   <= t_p[5];

      region6 <= region_c;
      seg6    <= seg_c;
      lo6[0]  <= nd_p[5] <= SD'(0);
      lo6[1]  <= ne_p[5] <= SD'(0);
      lo6[2]  <= bn_p[5] <= SD'(0);
      hi6[0]  <= nd_p[5] >= a_p[5];
      hi6[1]  <= ne_p[5] >= c_p[5];
      hi6[2]  <= bn_p[5] >= bd_p[5];

      x7         <= x_sel;
      y7         <= y_sel;
      u7         <= u_sel;
      w7         <= w_sel;
      den_p[7]   <= den_sel;
      base_p[7]  <= base_sel;
      rg_p[7]    <= region6;
      for (int k = 8; k <= 10; k++) begin
        den_p[k]  <= den_p[k-1];
        base_p[k] <= base_p[k-1];
        rg_p[k]   <= rg_p[k-1];
      end

      for (int i = 0; i < 3; i++) begin
        n10[i] <= ctp_pkg::NUM_W'(px[i]) + ctp_pkg::NUM_W'(py[i]);
      end
    end
  end

  ctp_mul #(.AW(68), .BW(68)) u_mul_ac (.clk(clk), .en(en), .a(a2), .b(c2), .p(p_ac));
  ctp_mul #(.AW(68), .BW(68)) u_mul_bb (.clk(clk), .en(en), .a(b2), .b(b2), .p(p_bb));
  ctp_mul #(.AW(68), .BW(68)) u_mul_be (.clk(clk), .en(en), .a(b2), .b(e2), .p(p_be));
  ctp_mul #(.AW(68), .BW(68)) u_mul_cd (.clk(clk), .en(en), .a(c2), .b(d2), .p(p_cd));
  ctp_mul #(.AW(68), .BW(68)) u_mul_bd (.clk(clk), .en(en), .a(b2), .b(d2), .p(p_bd));
  ctp_mul #(.AW(68), .BW(68)) u_mul_ae (.clk(clk), .en(en), .a(a2), .b(e2), .p(p_ae));

  assign sum5 = (WW+1)'(s_p[5]) + (WW+1)'(t_p[5]);
  assign lt5  = sum5 < (WW+1)'(det_p[5]);

  always_comb begin
    if (lt5) begin
      if (s_p[5][WW-1]) begin
        if (t_p[5][WW-1]) begin
          region_c = RGN_VERTEX_A;
          seg_c = dneg_p[5] ? SEG_AB : SEG_AC;
        end else begin
          region_c = RGN_AC;
          seg_c = SEG_AC;
        end
      end else if (t_p[5][WW-1]) begin
        region_c = RGN_AB;
        seg_c = SEG_AB;
      end else begin
        region_c = RGN_INTERIOR;
        seg_c = SEG_NONE;
      end
    end else begin
      if (s_p[5][WW-1]) begin
        region_c = RGN_BC_AC;
        seg_c = cegt_p[5] ? SEG_BC : SEG_AC;
      end else if (t_p[5][WW-1]) begin
        region_c = RGN_BC_AB;
        seg_c = adgt_p[5] ? SEG_BC : SEG_AB;
      end else begin
        region_c = RGN_BC;
        seg_c = SEG_BC;
      end
    end
  end

  always_comb begin
    unique case (seg6)
      SEG_AC: begin
        e_num = ne_p[6];
        e_den = c_p[6];
        e_lo  = lo6[1];
        e_hi  = hi6[1];
        e_p0  = pa_p[6];
        e_v   = e1_p[6];
      end
      SEG_BC: begin
        e_num = bn_p[6];
        e_den = bd_p[6];
        e_lo  = lo6[2];
        e_hi  = hi6[2];
        e_p0  = pc_p[6];
        e_v   = bc_p[6];
      end
      SEG_AB, SEG_NONE: begin
        e_num = nd_p[6];
        e_den = a_p[6];
        e_lo  = lo6[0];
        e_hi  = hi6[0];
        e_p0  = pa_p[6];
        e_v   = e0_p[6];
      end
    endcase

    y_sel = '0;
    w_sel = e1_p[6];
    u_sel = e_v;
    for (int i = 0; i < 3; i++) begin
      base_sel[i] = BS'($signed(e_p0[i]));
    end
    if (seg6 == SEG_NONE) begin
      x_sel   = s_p[6];
      y_sel   = t_p[6];
      u_sel   = e0_p[6];
      den_sel = det_p[6];
    end else begin
      priority if (e_lo) begin
        x_sel   = '0;
        den_sel = WW'(1);
      end else if (e_hi) begin
        x_sel   = '0;
        den_sel = WW'(1);
        for (int i = 0; i < 3; i++) begin
          base_sel[i] = BS'($signed(e_p0[i])) + BS'($signed(e_v[i]));
        end
      end else begin
        x_sel   = WW'(e_num);
        den_sel = WW'(e_den);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    ctp_mul #(.AW(WW), .BW(DW)) u_mul_x (
      .clk(clk), .en(en), .a(x7), .b($signed(u7[i])), .p(px[i])
    );
    ctp_mul #(.AW(WW), .BW(DW)) u_mul_y (
      .clk(clk), .en(en), .a(y7), .b($signed(w7[i])), .p(py[i])
    );
  end

  always_comb begin
    item.num    = n10;
    item.den    = den_p[10];
    item.base   = base_p[10];
    item.region = rg_p[10];
  end

endmodule

[sv/ctp_fifo.sv]
// Short transaction queue between the front and back pipelines.
module ctp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ctp_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output ctp_pkg::item_t dout,
  output logic           empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  ctp_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wr, rd;
  logic [CNTW-1:0] count;

  assign full  = count == CNTW'(DEPTH);
  assign empty = count == '0;
  assign dout  = mem[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= (wr == AW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (pop) begin
        rd <= (rd == AW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= din;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on write");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNTW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

[sv/ctp_back.sv]
// Back pipeline: rounded restoring division one quotient bit per stage, then saturation.
module ctp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  ctp_pkg::item_t item,
  output logic           pop,
  ctp_result_if.source   result
);

  localparam int QB  = ctp_pkg::QBITS;
  localparam int RMW = ctp_pkg::REM_W;
  localparam int DNW = ctp_pkg::DEN_W;
  localparam int NMW = ctp_pkg::NUM_W;
  localparam int BS  = ctp_pkg::BASE_W;
  localparam int SMW = QB + 2;
  localparam logic signed [SMW-1:0] SAT_HI = SMW'(2147483647);
  localparam logic signed [SMW-1:0] SAT_LO = -SAT_HI - SMW'(1);

  logic en;
  logic [QB:0] vld;
  logic ovld;

  logic [2:0][RMW-1:0] rem [QB+1];
  logic [2:0][QB-1:0]  quo [QB+1];
  logic [DNW:0]        dd  [QB+1];
  logic [2:0]          ng  [QB+1];
  logic [2:0][BS-1:0]  bs  [QB+1];
  logic [2:0]          rg  [QB+1];

  logic [2:0][NMW-1:0] mag;
  logic signed [SMW-1:0] sum [3];
  logic signed [31:0] sat [3];

  assign en  = !ovld || result.ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ovld <= 1'b0;
    end else if (en) begin
      vld  <= {vld[QB-1:0], !empty};
      ovld <= vld[QB];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = item.num[i][NMW-1] ? -item.num[i] : item.num[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= RMW'({mag[i], 1'b0}) + RMW'(item.den);
        ng[0][i]  <= item.num[i][NMW-1];
      end
      quo[0] <= '0;
      dd[0]  <= {item.den, 1'b0};
      bs[0]  <= item.base;
      rg[0]  <= item.region;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_step
    logic [RMW-1:0] cand;
    logic [2:0][RMW-1:0] rem_next;
    logic [2:0][QB-1:0] quo_next;
    assign cand = RMW'(dd[j-1]) << (QB - j);
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        quo_next[i] = quo[j-1][i];
        if (cand <= rem[j-1][i]) begin
          rem_next[i] = rem[j-1][i] - cand;
          quo_next[i][QB-j] = 1'b1;
        end else begin
          rem_next[i] = rem[j-1][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= rem_next;
        quo[j] <= quo_next;
        dd[j]  <= dd[j-1];
        ng[j]  <= ng[j-1];
        bs[j]  <= bs[j-1];
        rg[j]  <= rg[j-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SMW'($signed(bs[QB][i]))
             + (ng[QB][i] ? -SMW'({1'b0, quo[QB][i]}) : SMW'({1'b0, quo[QB][i]}));
      if (sum[i] > SAT_HI) begin
        sat[i] = 32'(SAT_HI);
      end else if (sum[i] < SAT_LO) begin
        sat[i] = 32'(SAT_LO);
      end else begin
        sat[i] = 32'(sum[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.closest_x <= sat[0];
      result.closest_y <= sat[1];
      result.closest_z <= sat[2];
      result.region    <= rg[QB];
    end
  end

  assign result.valid = ovld;

endmodule

[sv/closest_point_on_triangle.sv]
// Top level of the closest point on triangle block: front pipeline, queue, divider pipeline.
// A transaction passes through ten front stages, the queue memory register, the divider
// input stage, 41 quotient stages and the output register. Throughput is one transaction
// per cycle when neither the queue nor the result side stalls.
// Reset is synchronous and clears all valid bits and queue pointers.
// Each side stalls on its own; the queue holds QUEUE_DEPTH transactions between them.
module closest_point_on_triangle #(
  parameter int QUEUE_DEPTH = 4
) (
  input logic           clk,
  input logic           rst,
  ctp_query_if.sink     query,
  ctp_result_if.source  result
);

  logic push, full, pop, empty;
  ctp_pkg::item_t wr_item, rd_item;

  ctp_front u_front (
    .clk(clk), .rst(rst), .query(query), .full(full), .push(push), .item(wr_item)
  );

  ctp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .din(wr_item), .full(full),
    .pop(pop), .dout(rd_item), .empty(empty)
  );

  ctp_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .item(rd_item), .pop(pop), .result(result)
  );

endmodule

[tb/ctp_checker.sv]
// Checker for the closest point on triangle block: predicts each result and compares it.
module ctp_checker (
  input  logic  clk,
  input  logic  rst,
  ctp_query_if  query,
  ctp_result_if result,
  output int    failures,
  output int    pending,
  output int    checked,
  output int    region_seen [7]
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [2:0]         region;
  } closest_t;

  typedef enum logic [2:0] {
    REG_INTERIOR = 3'd0, REG_EDGE_BC = 3'd1, REG_BC_OR_AC = 3'd2, REG_EDGE_AC = 3'd3,
    REG_VERTEX_A = 3'd4, REG_EDGE_AB = 3'd5, REG_BC_OR_AB = 3'd6
  } region_e;

  closest_t closest_q[$];

  function automatic wide_t round_quot(input wide_t n, input wide_t d);
    logic  neg;
    wide_t m;
    wide_t qq;
    neg = n < 0;
    m = neg ? -n : n;
    qq = (2 * m + d) / (2 * d);
    return neg ? -qq : qq;
  endfunction

  function automatic void clamp_edge(input wide_t p0[3], input wide_t v[3], input wide_t num,
                                     input wide_t den, output wide_t r[3]);
    for (int i = 0; i < 3; i++) begin
      if (num <= 0) r[i] = p0[i];
      else if (num >= den) r[i] = p0[i] + v[i];
      else r[i] = p0[i] + round_quot(num * v[i], den);
    end
  endfunction

  function automatic wide_t dot(input wide_t u[3], input wide_t v[3]);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  function automatic logic signed [31:0] saturate(input wide_t v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic closest_t closest_point(input wide_t in[12]);
    wide_t   pa[3], pb[3], pc[3], e0[3], e1[3], dv[3], bc[3], r[3];
    wide_t   a, b, c, d, e, det, s, t, bcden, bcnum;
    region_e reg_code;
    closest_t res;
    for (int i = 0; i < 3; i++) begin
      pa[i] = in[i];
      pb[i] = in[3 + i];
      pc[i] = in[6 + i];
      e0[i] = pb[i] - pa[i];
      e1[i] = pc[i] - pa[i];
      dv[i] = pa[i] - in[9 + i];
      bc[i] = pb[i] - pc[i];
    end
    a = dot(e0, e0);
    b = dot(e0, e1);
    c = dot(e1, e1);
    d = dot(e0, dv);
    e = dot(e1, dv);
    det = a * c - b * b;
    s = b * e - c * d;
    t = b * d - a * e;
    bcden = a - 2 * b + c;
    bcnum = c + e - b - d;
    if (s + t < det) begin
      if (s < 0) begin
        if (t < 0) begin
          reg_code = REG_VERTEX_A;
          if (d < 0) clamp_edge(pa, e0, -d, a, r);
          else clamp_edge(pa, e1, -e, c, r);
        end else begin
          reg_code = REG_EDGE_AC;
          clamp_edge(pa, e1, -e, c, r);
        end
      end else if (t < 0) begin
        reg_code = REG_EDGE_AB;
        clamp_edge(pa, e0, -d, a, r);
      end else begin
        reg_code = REG_INTERIOR;
        for (int i = 0; i < 3; i++) r[i] = pa[i] + round_quot(s * e0[i] + t * e1[i], det);
      end
    end else if (s < 0) begin
      reg_code = REG_BC_OR_AC;
      if (c + e > b + d) clamp_edge(pc, bc, bcnum, bcden, r);
      else clamp_edge(pa, e1, -e, c, r);
    end else if (t < 0) begin
      reg_code = REG_BC_OR_AB;
      if (a + d > b + e) clamp_edge(pc, bc, bcnum, bcden, r);
      else clamp_edge(pa, e0, -d, a, r);
    end else begin
      reg_code = REG_EDGE_BC;
      clamp_edge(pc, bc, bcnum, bcden, r);
    end
    res.x = saturate(r[0]);
    res.y = saturate(r[1]);
    res.z = saturate(r[2]);
    res.region = reg_code;
    return res;
  endfunction

  assign pending = closest_q.size();

  always @(posedge clk) begin
    wide_t    in[12];
    closest_t exp_pt;
    if (rst) begin
      failures <= 0;
      checked <= 0;
      for (int i = 0; i < 7; i++) region_seen[i] <= 0;
    end else begin
      if (query.valid && query.ready) begin
        in = '{query.vertex_a_x, query.vertex_a_y, query.vertex_a_z,
               query.vertex_b_x, query.vertex_b_y, query.vertex_b_z,
               query.vertex_c_x, query.vertex_c_y, query.vertex_c_z,
               query.query_x, query.query_y, query.query_z};
        closest_q = {closest_q, closest_point(in)};
      end
      if (result.valid && result.ready) begin
        checked <= checked + 1;
        if (closest_q.size() == 0) begin
          $display("%0t: unexpected result transaction (%0d %0d %0d region %0d)", $time,
                   result.closest_x, result.closest_y, result.closest_z, result.region);
          failures <= failures + 1;
        end else begin
          exp_pt = closest_q.pop_front();
          region_seen[exp_pt.region] <= region_seen[exp_pt.region] + 1;
          if (result.closest_x !== exp_pt.x || result.closest_y !== exp_pt.y ||
              result.closest_z !== exp_pt.z || result.region !== exp_pt.region) begin
            $display("%0t: mismatch expected (%0d %0d %0d region %0d) actual (%0d %0d %0d region %0d)",
                     $time, exp_pt.x, exp_pt.y, exp_pt.z, exp_pt.region, result.closest_x,
                     result.closest_y, result.closest_z, result.region);
            failures <= failures + 1;
          end
        end
      end
    end
  end

endmodule

[tb/testbench.sv]
// Top of the closest point on triangle testbench: stimulus, flow control and verdict.
module testbench;

  typedef logic signed [31:0] query_vec_t [12];

  localparam int ONE = 65536;
  localparam int RANDOM_QUERIES = 530;
  localparam int IDLE_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  int   failures, pending, checked, sent, idle_cycles;
  int   region_seen [7];

  ctp_query_if  q_if ();
  ctp_result_if r_if ();

  closest_point_on_triangle dut (.clk(clk), .rst(rst), .query(q_if), .result(r_if));

  ctp_checker checker_i (
    .clk(clk), .rst(rst), .query(q_if), .result(r_if), .failures(failures),
    .pending(pending), .checked(checked), .region_seen(region_seen)
  );

  always #2 clk = ~clk;

  function automatic logic no_idle_phase();
    return sent >= 200 && sent < 300;
  endfunction

  task automatic send(input query_vec_t v);
    int gap;
    gap = no_idle_phase() ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      q_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    q_if.vertex_a_x <= v[0];
    q_if.vertex_a_y <= v[1];
    q_if.vertex_a_z <= v[2];
    q_if.vertex_b_x <= v[3];
    q_if.vertex_b_y <= v[4];
    q_if.vertex_b_z <= v[5];
    q_if.vertex_c_x <= v[6];
    q_if.vertex_c_y <= v[7];
    q_if.vertex_c_z <= v[8];
    q_if.query_x <= v[9];
    q_if.query_y <= v[10];
    q_if.query_z <= v[11];
    q_if.valid <= 1'b1;
    do @(posedge clk); while (!q_if.ready);
    sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] coord();
    return $urandom_range(0, 2 * (1 << 21)) - (1 << 21);
  endfunction

  task automatic send_unit(input int qx, input int qy, input int qz);
    send('{0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0, qx * ONE / 2, qy * ONE / 2, qz * ONE / 2});
  endtask

  initial begin
    query_vec_t v;
    int kind;
    q_if.valid = 0;
    r_if.ready = 0;
    {q_if.vertex_a_x, q_if.vertex_a_y, q_if.vertex_a_z, q_if.vertex_b_x, q_if.vertex_b_y,
     q_if.vertex_b_z, q_if.vertex_c_x, q_if.vertex_c_y, q_if.vertex_c_z, q_if.query_x,
     q_if.query_y, q_if.query_z} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Query points in each of the seven regions of a right triangle, then edge cases.
    send_unit(2, 2, 3);
    send_unit(6, 6, 1);
    send_unit(-2, 10, 0);
    send_unit(-2, 2, -1);
    send_unit(-2, -2, 0);
    send_unit(2, -2, 2);
    send_unit(10, -2, 0);
    send_unit(4, 4, 0);
    send('{default: 0});
    send('{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 0, 0, 0});
    send('{0, 0, 0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 5 * ONE, 0, 0});
    send('{default: 32'sh7fffffff});
    send('{default: 32'sh80000000});
    send('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
           32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
           32'sh7fffffff, 32'sh7fffffff});
    send('{32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff,
           32'sh80000000, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff});
    send('{0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0});

    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == 300) begin
        q_if.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
      end
      kind = $urandom_range(0, 19);
      for (int i = 0; i < 12; i++) v[i] = (kind < 5) ? $urandom : coord();
      if (kind == 5) v[3:5] = v[0:2];
      if (kind == 6) for (int i = 0; i < 3; i++) v[6 + i] = 2 * v[3 + i] - v[i];
      if (kind == 7) v[9:11] = v[6:8];
      send(v);
    end
    q_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (80) @(posedge clk);
    $display("Sent %0d queries, checked %0d results; regions 0..6 seen %0d %0d %0d %0d %0d %0d %0d.",
             sent, checked, region_seen[0], region_seen[1], region_seen[2], region_seen[3],
             region_seen[4], region_seen[5], region_seen[6]);
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = no_idle_phase() ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        r_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      r_if.ready <= 1'b1;
      do @(posedge clk); while (!r_if.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles at %0t.", IDLE_LIMIT, $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
